// File: rtl/ipm_bilinear_sampler_core_defines.svh
`ifndef IPM_BILINEAR_SAMPLER_CORE_DEFINES_SVH
`define IPM_BILINEAR_SAMPLER_CORE_DEFINES_SVH

// same-cycle implication, checked on clk outside reset
`define IPM_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked on clk outside reset
`define IPM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/ipm_bs_pkg.sv
package ipm_bs_pkg;

	localparam int COORD_W     = 17;
	localparam int WIN_COL_W   = 10;
	localparam int WIN_ROW_W   = 9;
	localparam int PIXEL_W     = 8;
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 10;

	localparam int DEF_IMAGE_WIDTH     = 640;
	localparam int DEF_IMAGE_HEIGHT    = 480;
	localparam int DEF_COORD_FRAC_BITS = 6;

	localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_LEFT   = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_RIGHT  = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_TOP    = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_BOTTOM = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_NEAREST_MODE  = 3'd4;

	localparam logic [WIN_COL_W-1:0] RST_WINDOW_RIGHT  = 10'd639;
	localparam logic [WIN_ROW_W-1:0] RST_WINDOW_BOTTOM = 9'd479;

	localparam int BORDER_COLS = 10;
	localparam int BORDER_ROWS = 2;

endpackage

// File: rtl/ipm_bilinear_sampler_core.sv
// Remap sampler with a single-port frame store. A load item does not occupy the block: it
// writes the pixel at the running raster address and updates the pixel sum. A sample item
// occupies the block until its result is registered: nearest sampling makes one frame read,
// bilinear sampling makes four neighbour reads, one per cycle through the one read port, each
// multiplied and accumulated in the following cycle, and an out-of-window sample takes the
// frame mean, which comes from one multiplication of the pixel sum by the reciprocal of the
// frame size. A new item is taken while the previous result still waits in the output
// register; a sample that finishes while that result is still not taken waits in its final
// state until the output register frees up.
module ipm_bilinear_sampler_core
	import ipm_bs_pkg::*;
#(
	parameter int IMAGE_WIDTH     = DEF_IMAGE_WIDTH,
	parameter int IMAGE_HEIGHT    = DEF_IMAGE_HEIGHT,
	parameter int COORD_FRAC_BITS = DEF_COORD_FRAC_BITS
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_write,
	input  logic [CFG_INDEX_W-1:0]    cfg_index,
	input  logic [CFG_DATA_W-1:0]     cfg_data,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic                      command,
	input  logic [PIXEL_W-1:0]        pixel_in,
	input  logic signed [COORD_W-1:0] u_coord,
	input  logic signed [COORD_W-1:0] v_coord,
	input  logic                      u_unknown,
	input  logic                      v_unknown,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [PIXEL_W-1:0]        sample_value,
	output logic                      used_fill,
	output logic                      near_border
);

	localparam int F      = COORD_FRAC_BITS;
	localparam int FRAME  = IMAGE_WIDTH * IMAGE_HEIGHT;
	localparam int AW     = $clog2(FRAME);
	localparam int CW     = $clog2(IMAGE_WIDTH);
	localparam int RW     = $clog2(IMAGE_HEIGHT);
	localparam int SW     = $clog2(255 * FRAME + 1);
	localparam int XW     = COORD_W + 1;
	localparam int CMPW   = COORD_W + F + 2;
	localparam int WW     = 2 * F + 2;
	localparam int ACCW   = 2 * F + 10;
	localparam int DIV_SH = SW + AW;
	localparam int RCPW   = SW + 2;
	localparam int MPW    = SW + RCPW;

	// ceil(2^DIV_SH / FRAME), exact floor for every sum below 2^SW
	localparam logic [RCPW-1:0] RECIP =
		RCPW'(((64'd1 << DIV_SH) + 64'(FRAME) - 64'd1) / 64'(FRAME));

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_BIL  = 3'd1;
	localparam logic [2:0] ST_NEAR = 3'd2;
	localparam logic [2:0] ST_NWT  = 3'd3;
	localparam logic [2:0] ST_DIV  = 3'd4;
	localparam logic [2:0] ST_DONE = 3'd5;

	function automatic logic [CW-1:0] clamp_col(input logic signed [XW-1:0] x);
		logic [CW-1:0] r;
		if (x < 0) r = '0;
		else if (x > XW'(IMAGE_WIDTH - 1)) r = CW'(IMAGE_WIDTH - 1);
		else r = x[CW-1:0];
		return r;
	endfunction

	function automatic logic [RW-1:0] clamp_row(input logic signed [XW-1:0] x);
		logic [RW-1:0] r;
		if (x < 0) r = '0;
		else if (x > XW'(IMAGE_HEIGHT - 1)) r = RW'(IMAGE_HEIGHT - 1);
		else r = x[RW-1:0];
		return r;
	endfunction

	logic [WIN_COL_W-1:0] win_left_q, win_right_q;
	logic [WIN_ROW_W-1:0] win_top_q, win_bottom_q;
	logic                 nearest_q;

	logic [2:0]        state_q;
	logic [AW-1:0]     load_addr_q;
	logic [SW-1:0]     sum_q;
	logic [2:0]        step_q;
	logic [CW-1:0]     c0_q, c1_q;
	logic [RW-1:0]     r0_q, r1_q;
	logic [F-1:0]      fx_q, fy_q;
	logic [WW-1:0]     w_q;
	logic [ACCW-1:0]   acc_q;
	logic [PIXEL_W-1:0] res_q;
	logic              fill_q, border_q;
	logic [PIXEL_W-1:0] rd_q;

	logic [PIXEL_W-1:0] mem [FRAME];

	logic in_acc, mem_we, rd_en, out_load;
	logic [RW-1:0] rd_row;
	logic [CW-1:0] rd_col;
	logic [AW-1:0] rd_addr;
	logic [F:0]    wx, wy;
	logic [ACCW-1:0] acc_next;
	logic [MPW-1:0] mean_prod;

	logic signed [XW-1:0]   u_x, v_x, ci, ri, nu, nv;
	logic signed [CMPW-1:0] u_c, v_c, lo_u, hi_u, lo_v, hi_v, bl_u, br_u, bb_v;
	logic fill_now, border_now;

	assign in_ready = (state_q == ST_IDLE);
	assign in_acc   = in_valid && in_ready;
	assign mem_we   = in_acc && !command;
	assign out_load = (state_q == ST_DONE) && (!out_valid || out_ready);

	always_comb begin
		u_x  = u_unknown ? '0 : XW'(u_coord);
		v_x  = v_unknown ? '0 : XW'(v_coord);
		ci   = u_x >>> F;
		ri   = v_x >>> F;
		nu   = (u_x + XW'(1 << (F - 1))) >>> F;
		nv   = (v_x + XW'(1 << (F - 1))) >>> F;
		u_c  = CMPW'(u_x);
		v_c  = CMPW'(v_x);
		lo_u = CMPW'(win_left_q) <<< F;
		hi_u = CMPW'(win_right_q) <<< F;
		lo_v = CMPW'(win_top_q) <<< F;
		hi_v = CMPW'(win_bottom_q) <<< F;
		bl_u = (CMPW'(win_left_q) + CMPW'(BORDER_COLS)) <<< F;
		br_u = (CMPW'(win_right_q) - CMPW'(BORDER_COLS)) <<< F;
		bb_v = (CMPW'(win_bottom_q) - CMPW'(BORDER_ROWS)) <<< F;
		fill_now   = (u_c < lo_u) || (u_c > hi_u) || (v_c < lo_v) || (v_c > hi_v);
		border_now = (u_c < bl_u) || (u_c > br_u) || (v_c < lo_v) || (v_c > bb_v);
	end

	always_comb begin
		rd_en  = 1'b0;
		rd_row = r0_q;
		rd_col = c0_q;
		if (state_q == ST_BIL) begin
			rd_en  = (step_q != 3'd4);
			rd_row = step_q[1] ? r1_q : r0_q;
			rd_col = step_q[0] ? c1_q : c0_q;
		end else if (state_q == ST_NEAR) begin
			rd_en = 1'b1;
		end
		rd_addr = AW'(rd_row * IMAGE_WIDTH) + AW'(rd_col);
		wx = step_q[0] ? (F+1)'(fx_q) : (F+1)'((1 << F) - int'(fx_q));
		wy = step_q[1] ? (F+1)'(fy_q) : (F+1)'((1 << F) - int'(fy_q));
		acc_next  = acc_q + ACCW'(rd_q * w_q);
		mean_prod = MPW'(sum_q) * MPW'(RECIP);
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[load_addr_q] <= pixel_in;
		if (rd_en) rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_left_q   <= '0;
			win_right_q  <= RST_WINDOW_RIGHT;
			win_top_q    <= '0;
			win_bottom_q <= RST_WINDOW_BOTTOM;
			nearest_q    <= 1'b0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_WINDOW_LEFT:   win_left_q   <= cfg_data[WIN_COL_W-1:0];
				REG_WINDOW_RIGHT:  win_right_q  <= cfg_data[WIN_COL_W-1:0];
				REG_WINDOW_TOP:    win_top_q    <= cfg_data[WIN_ROW_W-1:0];
				REG_WINDOW_BOTTOM: win_bottom_q <= cfg_data[WIN_ROW_W-1:0];
				REG_NEAREST_MODE:  nearest_q    <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			load_addr_q <= '0;
			sum_q       <= '0;
			out_valid   <= 1'b0;
		end else begin
			if (out_load) out_valid <= 1'b1;
			else if (out_ready) out_valid <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (mem_we) begin
						sum_q <= (load_addr_q == '0) ? SW'(pixel_in) : sum_q + SW'(pixel_in);
						load_addr_q <= (load_addr_q == AW'(FRAME - 1)) ? '0 : load_addr_q + 1'b1;
					end else if (in_acc) begin
						if (fill_now) state_q <= ST_DIV;
						else if (nearest_q) state_q <= ST_NEAR;
						else state_q <= ST_BIL;
					end
				end
				ST_BIL: if (step_q == 3'd4) state_q <= ST_DONE;
				ST_NEAR: state_q <= ST_NWT;
				ST_NWT: state_q <= ST_DONE;
				ST_DIV: state_q <= ST_DONE;
				ST_DONE: if (out_load) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				fill_q    <= fill_now;
				border_q  <= border_now;
				step_q    <= '0;
				acc_q     <= '0;
				res_q     <= '0;
				fx_q      <= u_x[F-1:0];
				fy_q      <= v_x[F-1:0];
				c1_q      <= clamp_col(ci + XW'(1));
				r1_q      <= clamp_row(ri + XW'(1));
				if (nearest_q) begin
					c0_q <= clamp_col(nu);
					r0_q <= clamp_row(nv);
				end else begin
					c0_q <= clamp_col(ci);
					r0_q <= clamp_row(ri);
				end
			end
			ST_BIL: begin
				w_q    <= WW'(wx * wy);
				step_q <= step_q + 1'b1;
				if (step_q != '0) acc_q <= acc_next;
				if (step_q == 3'd4) res_q <= acc_next[2*F +: PIXEL_W];
			end
			ST_NWT: res_q <= rd_q;
			ST_DIV: res_q <= mean_prod[DIV_SH +: PIXEL_W];
			ST_DONE: begin
				if (out_load) begin
					sample_value <= res_q;
					used_fill    <= fill_q;
					near_border  <= border_q;
				end
			end
			default: ;
		endcase
	end

endmodule

// File: rtl/ipm_bs_checker.sv
`include "ipm_bilinear_sampler_core_defines.svh"

module ipm_bs_checker
	import ipm_bs_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               command,
	input logic               out_valid,
	input logic               out_ready,
	input logic [PIXEL_W-1:0] sample_value
);

	`IPM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(sample_value), "result changed while stalled")
	`IPM_ASSERT_NEXT(a_load_silent, in_valid && in_ready && !command && !out_valid, !out_valid, "load item produced a result")
	`IPM_ASSERT_NEXT(a_sample_busy, in_valid && in_ready && command, !in_ready, "item taken while a sample is in progress")

endmodule

bind ipm_bilinear_sampler_core ipm_bs_checker u_ipm_bs_checker (.*);

// File: tb/ipm_bilinear_sampler_core_tb.sv
module ipm_bilinear_sampler_core_tb;
	import ipm_bs_pkg::*;

	localparam int FRAC       = DEF_COORD_FRAC_BITS;
	localparam longint ONE    = longint'(1) << FRAC;
	localparam int FRAME_SIZE = DEF_IMAGE_WIDTH * DEF_IMAGE_HEIGHT;
	localparam int FILL_SIZE  = 2 * DEF_IMAGE_WIDTH;
	localparam int WATCHDOG   = 5000;
	localparam int DRAIN      = 20;

	typedef struct {
		logic [PIXEL_W-1:0] value;
		logic               fill;
		logic               border;
	} pixel_result_t;

	class sampler_scoreboard;
		byte unsigned frame[];
		int unsigned load_addr;
		longint unsigned pixel_sum;
		longint left, right, top, bottom;
		bit nearest;
		pixel_result_t pending[$];
		int errors;

		function new();
			frame = new[FRAME_SIZE];
			load_addr = 0;
			pixel_sum = 0;
			left = 0;
			right = RST_WINDOW_RIGHT;
			top = 0;
			bottom = RST_WINDOW_BOTTOM;
			nearest = 0;
			errors = 0;
		endfunction

		function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
			case (idx)
				REG_WINDOW_LEFT: left = d[WIN_COL_W-1:0];
				REG_WINDOW_RIGHT: right = d[WIN_COL_W-1:0];
				REG_WINDOW_TOP: top = d[WIN_ROW_W-1:0];
				REG_WINDOW_BOTTOM: bottom = d[WIN_ROW_W-1:0];
				REG_NEAREST_MODE: nearest = d[0];
				default: ;
			endcase
		endfunction

		function int clip(longint x, int hi);
			if (x < 0) return 0;
			if (x > hi) return hi;
			return int'(x);
		endfunction

		function longint pixel_at(int r, int c);
			return frame[r * DEF_IMAGE_WIDTH + c];
		endfunction

		function void note_item(bit cmd, logic [PIXEL_W-1:0] p, logic signed [COORD_W-1:0] uc,
				logic signed [COORD_W-1:0] vc, bit uu, bit vu);
			longint u, v, acc, fx, fy, gx, gy;
			int c0, c1, r0, r1;
			pixel_result_t r;
			if (!cmd) begin
				frame[load_addr] = p;
				if (load_addr == 0) pixel_sum = p;
				else pixel_sum += p;
				load_addr = (load_addr + 1) % FRAME_SIZE;
				return;
			end
			u = uu ? 0 : longint'(uc);
			v = vu ? 0 : longint'(vc);
			r.fill = (u < left * ONE) || (u > right * ONE) || (v < top * ONE) || (v > bottom * ONE);
			if (r.fill) begin
				acc = pixel_sum / FRAME_SIZE;
			end else if (nearest) begin
				c0 = clip((u + ONE / 2) >>> FRAC, DEF_IMAGE_WIDTH - 1);
				r0 = clip((v + ONE / 2) >>> FRAC, DEF_IMAGE_HEIGHT - 1);
				acc = pixel_at(r0, c0);
			end else begin
				fx = u & (ONE - 1);
				fy = v & (ONE - 1);
				gx = ONE - fx;
				gy = ONE - fy;
				c0 = clip(u >>> FRAC, DEF_IMAGE_WIDTH - 1);
				c1 = clip((u >>> FRAC) + 1, DEF_IMAGE_WIDTH - 1);
				r0 = clip(v >>> FRAC, DEF_IMAGE_HEIGHT - 1);
				r1 = clip((v >>> FRAC) + 1, DEF_IMAGE_HEIGHT - 1);
				acc = (pixel_at(r0, c0) * gx * gy + pixel_at(r0, c1) * fx * gy +
					pixel_at(r1, c0) * gx * fy + pixel_at(r1, c1) * fx * fy) >> (2 * FRAC);
			end
			r.value = acc > 255 ? 8'd255 : acc[7:0];
			r.border = (u < (left + BORDER_COLS) * ONE) || (u > (right - BORDER_COLS) * ONE) ||
				(v < top * ONE) || (v > (bottom - BORDER_ROWS) * ONE);
			pending = {pending, r};
		endfunction

		function void check_result(logic [PIXEL_W-1:0] value, logic fill, logic border);
			pixel_result_t e;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result: value %0d fill %0b border %0b",
						value, fill, border);
				return;
			end
			e = pending.pop_front();
			if (value !== e.value || fill !== e.fill || border !== e.border) begin
				errors++;
				if (errors <= 10)
					$display("mismatch: expected value %0d fill %0b border %0b, got %0d %0b %0b",
						e.value, e.fill, e.border, value, fill, border);
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n;
	logic cfg_write;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic in_valid, in_ready;
	logic command;
	logic [PIXEL_W-1:0] pixel_in;
	logic signed [COORD_W-1:0] u_coord, v_coord;
	logic u_unknown, v_unknown;
	logic out_valid, out_ready;
	logic [PIXEL_W-1:0] sample_value;
	logic used_fill, near_border;

	sampler_scoreboard sb;
	int send_idle_pct;
	int recv_stall_pct;
	int quiet_cycles;

	ipm_bilinear_sampler_core uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.command(command), .pixel_in(pixel_in), .u_coord(u_coord), .v_coord(v_coord),
		.u_unknown(u_unknown), .v_unknown(v_unknown),
		.out_valid(out_valid), .out_ready(out_ready),
		.sample_value(sample_value), .used_fill(used_fill), .near_border(near_border)
	);

	always begin
		#2 clk = 1;
		#2 clk = 0;
	end

	always @(negedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (out_valid && out_ready)
				sb.check_result(sample_value, used_fill, near_border);
			if (quiet_cycles >= WATCHDOG) begin
				$display("FAILURE");
				$finish;
			end
		end
	end

	task automatic send_item(bit cmd, logic [PIXEL_W-1:0] p, logic signed [COORD_W-1:0] uc,
			logic signed [COORD_W-1:0] vc, bit uu, bit vu);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 0;
			@(negedge clk);
		end
		in_valid <= 1;
		command <= cmd;
		pixel_in <= p;
		u_coord <= uc;
		v_coord <= vc;
		u_unknown <= uu;
		v_unknown <= vu;
		do @(posedge clk); while (!in_ready);
		sb.note_item(cmd, p, uc, vc, uu, vu);
		@(negedge clk);
	endtask

	task automatic sample_at(longint uc, longint vc);
		send_item(1'b1, PIXEL_W'($urandom), uc[COORD_W-1:0], vc[COORD_W-1:0], 1'b0, 1'b0);
	endtask

	task automatic settle();
		in_valid <= 0;
		@(negedge clk);
		while (sb.pending.size() != 0) @(negedge clk);
		repeat (DRAIN) @(negedge clk);
	endtask

	task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
		cfg_write <= 1;
		cfg_index <= idx;
		cfg_data <= d;
		sb.write_reg(idx, d);
		@(negedge clk);
		cfg_write <= 0;
	endtask

	task automatic set_window(int l, int r, int t, int b, bit nm);
		settle();
		write_reg(REG_WINDOW_LEFT, CFG_DATA_W'(l));
		write_reg(REG_WINDOW_RIGHT, CFG_DATA_W'(r));
		write_reg(REG_WINDOW_TOP, CFG_DATA_W'(t));
		write_reg(REG_WINDOW_BOTTOM, CFG_DATA_W'(b));
		write_reg(REG_NEAREST_MODE, CFG_DATA_W'(nm));
	endtask

	function automatic logic signed [COORD_W-1:0] near_coord(longint lo, longint hi);
		longint whole;
		longint frac;
		whole = longint'($urandom_range(32'(hi - lo + 4))) + lo - 2;
		case ($urandom_range(3))
			0: frac = 0;
			1: frac = ONE / 2;
			default: frac = $urandom_range(32'(ONE - 1));
		endcase
		return COORD_W'(whole * ONE + frac);
	endfunction

	// the initial fill loads rows 0 and 1, so rows inside the window stay below one pixel
	function automatic logic signed [COORD_W-1:0] row_coord(longint bot);
		longint v;
		case ($urandom_range(5))
			0: v = 0;
			1: v = ONE / 2;
			2: v = -1 - longint'($urandom_range(32'(4 * ONE)));
			3: v = bot * ONE + 1 + longint'($urandom_range(32'(4 * ONE)));
			default: v = $urandom_range(32'(ONE - 1));
		endcase
		return COORD_W'(v);
	endfunction

	task automatic random_item();
		int kind;
		kind = $urandom_range(99);
		if (kind < 20) begin
			send_item(1'b0, PIXEL_W'($urandom), COORD_W'($urandom), COORD_W'($urandom),
				1'($urandom), 1'($urandom));
		end else if (kind < 30) begin
			send_item(1'b1, PIXEL_W'($urandom), COORD_W'($urandom), COORD_W'($urandom),
				1'($urandom), 1'b1);
		end else begin
			send_item(1'b1, PIXEL_W'($urandom), near_coord(sb.left, sb.right),
				row_coord(sb.bottom), $urandom_range(19) == 0, $urandom_range(19) == 0);
		end
	endtask

	task automatic random_window();
		case ($urandom_range(4))
			0: set_window(0, 639, 0, 479, 1'($urandom));
			1: set_window(0, 1023, 0, 511, 1'($urandom));
			2: set_window(1023, 1023, 511, 511, 1'($urandom));
			3: set_window($urandom_range(700), $urandom_range(1023, 300), 0,
				$urandom_range(3), 1'($urandom));
			default: set_window($urandom_range(700), $urandom_range(1023, 300),
				$urandom_range(400), $urandom_range(511, 200), 1'($urandom));
		endcase
	endtask

	initial begin
		int phase_idle[4] = '{0, 61, 0, 18};
		int phase_stall[4] = '{0, 0, 61, 18};
		sb = new();
		arst_n = 0;
		cfg_write = 0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 0;
		command = 0;
		pixel_in = '0;
		u_coord = '0;
		v_coord = '0;
		u_unknown = 0;
		v_unknown = 0;
		out_ready = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		quiet_cycles = 0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// load the first two rows, every sample stays within them
		for (int i = 0; i < FILL_SIZE; i++)
			send_item(1'b0, (i < 4) ? 8'd255 : (i < 8) ? 8'd0 : 8'($urandom),
				COORD_W'($urandom), COORD_W'($urandom), 1'($urandom), 1'($urandom));

		sample_at(0, 0);
		sample_at(639 * ONE, 0);
		sample_at(5 * ONE + 17, 45);
		sample_at(-1, 10 * ONE);
		sample_at(10 * ONE, -1);
		sample_at(640 * ONE, 0);
		sample_at(-65536, 65535);
		sample_at(65535, -65536);
		send_item(1'b1, 8'hff, 17'h1ffff, 17'h10000, 1'b1, 1'b1);
		send_item(1'b1, 8'h00, 17'h10000, COORD_W'(ONE / 2), 1'b1, 1'b0);
		send_item(1'b1, 8'h00, COORD_W'(7 * ONE), 17'h0ffff, 1'b0, 1'b1);
		set_window(0, 1023, 0, 511, 0);
		sample_at(639 * ONE + 40, 20);
		sample_at(1023 * ONE, 0);
		set_window(0, 1023, 0, 511, 1);
		sample_at(ONE / 2, ONE / 2 - 1);
		sample_at(639 * ONE + ONE / 2, ONE / 2);
		sample_at(100 * ONE + 31, ONE + 31);
		set_window(20, 20, 0, 0, 0);
		sample_at(20 * ONE, 0);
		sample_at(20 * ONE + 1, 0);

		for (int ph = 0; ph < 4; ph++) begin
			for (int w = 0; w < 4; w++) begin
				random_window();
				send_idle_pct = phase_idle[ph];
				recv_stall_pct = phase_stall[ph];
				repeat (34) random_item();
				send_idle_pct = 0;
				recv_stall_pct = 0;
			end
		end

		settle();
		if (sb.errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
